/* sv/positional_list_store_core_defines.svh */
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PLSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PLSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/plsc_pkg.sv */
// Package: types, constants and helpers of the positional list store.
`default_nettype none

package plsc_pkg;

    localparam int DEPTH = 16;
    // Width of an entry index and of the word count.
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int POSW  = 5;
    localparam int LENW  = 5;
    // Compare width: wide enough for a position, the count and count + 1.
    localparam int CMPW  = ((CW > POSW) ? CW : POSW) + 1;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_INS,
        S_PUT,
        S_REM0,
        S_REM,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [POSW-1:0]    position;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] data;
        t_status            status;
        logic [LENW-1:0]    length;
        logic               empty_res;
    } t_out_res;

    // Length field keeps the low bits of the count.
    function automatic logic [LENW-1:0] to_len(input logic [CW-1:0] cnt);
        logic [CMPW-1:0] wide;
        wide = CMPW'(cnt);
        return wide[LENW-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/positional_list_store_core.sv */
// Top level: positional list store with a single-port-write word memory.
//
// Usage
//   Requests enter on i_in_req with i_in_valid; a request is taken at a rising
//   edge with i_in_valid high and o_in_stall low. Each request gives exactly
//   one result on o_out_res with o_out_valid, taken at an edge where
//   i_out_stall is low. Results come out in request order.
//   Write, append-insert, invalid and full requests need no memory walk; a
//   read waits for the registered memory read; insert and remove at position
//   p walk the words from p to the tail.
//   One request is at work at a time; the walk over the word memory (one read
//   and one write-back per cycle) sets the rate. A request may be taken while
//   the previous result still waits in the output register.
//   If the receiver stalls, the finished result waits in the output
//   register and the next result waits in the working registers; o_in_stall
//   stays high until that result has moved on.
//   Reset (i_rst_n low, synchronous) empties the list and drops any result;
//   the word memory itself is not cleared.
`default_nettype none

module positional_list_store_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire plsc_pkg::t_in_req i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output plsc_pkg::t_out_res     o_out_res
);
    import plsc_pkg::*;

    `include "positional_list_store_core_defines.svh"

    // Word memory: one write and one registered read per cycle.
    logic [31:0] mem [DEPTH];
    logic [31:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Control and working registers.
    t_state        r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] r_idx,    n_idx;
    logic [AW-1:0] r_pos_idx, n_pos_idx;
    logic [31:0]   r_val,    n_val;
    logic [31:0]   r_data,   n_data;
    t_status       r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_out_res      r_out,    n_out;

    // Request decode.
    logic            in_acc;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] pos_m1;
    logic            in_list;
    logic            ins_ok;
    logic            full;
    logic            out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign pos_w    = CMPW'(i_in_req.position);
    assign cnt_w    = CMPW'(r_count);
    assign pos_m1   = pos_w - CMPW'(1);
    assign in_list  = (pos_w != '0) && (pos_w <= cnt_w);
    assign ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1));
    assign full     = (r_count == CW'(DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_pos_idx <= n_pos_idx;
        r_val     <= n_val;
        r_data    <= n_data;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos_idx   = r_pos_idx;
        n_val       = r_val;
        n_data      = r_data;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rd_data;
        mem_raddr   = r_idx;

        // Drop the shown result once the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pos_idx = pos_m1[AW-1:0];
                    n_val     = i_in_req.value;
                    n_data    = '1;
                    n_status  = ST_INVALID;
                    n_state   = S_DONE;
                    case (i_in_req.action)
                        ACT_READ: begin
                            if (in_list) begin
                                mem_raddr = pos_m1[AW-1:0];
                                n_state   = S_RD;
                            end
                        end
                        ACT_WRITE: begin
                            if (in_list) begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_m1[AW-1:0];
                                mem_wdata = i_in_req.value;
                                n_data    = i_in_req.value;
                                n_status  = ST_OK;
                            end
                        end
                        ACT_INSERT: begin
                            if (ins_ok) begin
                                n_data = i_in_req.value;
                                if (full) begin
                                    n_status = ST_FULL;
                                end else if (pos_w == cnt_w + CMPW'(1)) begin
                                    // Append at the tail: no words move.
                                    mem_we    = 1'b1;
                                    mem_waddr = AW'(r_count);
                                    mem_wdata = i_in_req.value;
                                    n_count   = r_count + CW'(1);
                                    n_status  = ST_OK;
                                end else begin
                                    // Move words back, starting at the tail.
                                    mem_raddr = AW'(r_count - CW'(1));
                                    n_idx     = AW'(r_count);
                                    n_state   = S_INS;
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (in_list) begin
                                mem_raddr = pos_m1[AW-1:0];
                                n_state   = S_REM0;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_data   = r_rd_data;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_INS: begin
                // Word read last cycle from r_idx - 1 goes to r_idx.
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd_data;
                if (r_idx == r_pos_idx + AW'(1)) begin
                    n_state = S_PUT;
                end else begin
                    mem_raddr = r_idx - AW'(2);
                    n_idx     = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos_idx;
                mem_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_data    = r_val;
                n_status  = ST_OK;
                n_state   = S_DONE;
            end
            S_REM0: begin
                n_data   = r_rd_data;
                n_status = ST_OK;
                if (CMPW'(r_pos_idx) + CMPW'(1) == CMPW'(r_count)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    mem_raddr = r_pos_idx + AW'(1);
                    n_idx     = r_pos_idx;
                    n_state   = S_REM;
                end
            end
            S_REM: begin
                // Close the gap: the word read from r_idx + 1 goes to r_idx.
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd_data;
                if (CMPW'(r_idx) + CMPW'(2) < CMPW'(r_count)) begin
                    mem_raddr = r_idx + AW'(2);
                    n_idx     = r_idx + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    n_out.data      = r_data;
                    n_out.status    = r_status;
                    n_out.length    = to_len(r_count);
                    n_out.empty_res = (r_count == '0);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PLSC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "word count above depth")
    `PLSC_ASSERT_NEXT(a_count_only_at_end, 1'b1, (r_count == $past(r_count)) || (r_state == S_DONE), "word count changed outside a command end")
    `PLSC_ASSERT_NOW(a_rise_from_done, $rose(o_out_valid), $past(r_state) == S_DONE, "result shown without a finished command")
    `PLSC_ASSERT_NOW(a_walk_no_clash, mem_we && (n_state == S_INS || n_state == S_REM), mem_waddr != mem_raddr, "memory walk writes the entry it reads")

endmodule

`default_nettype wire

/* tb/positional_list_checker.sv */
// Checker: predicts each positional list store result and compares it with the block's output.
`default_nettype none

module positional_list_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire plsc_pkg::t_in_req  i_in_req,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire plsc_pkg::t_out_res i_out_res,
    output int                      o_errors,
    output int                      o_pending
);
    import plsc_pkg::*;

    localparam int LW = LENW;

    // Shadow of the list contents and length.
    logic [31:0] shadow_words [DEPTH];
    int          shadow_count;

    t_out_res    expected_q [$];
    t_out_res    predicted_res;
    t_out_res    oldest_res;

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        shadow_count = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got_val,
                                   input logic [31:0] exp_val);
        $display("positional_list_checker: %s mismatch, got %0h expected %0h at %0t",
                 field, got_val, exp_val, $realtime);
        o_errors++;
    endtask

    // Apply one request to the shadow list and work out its result.
    task automatic apply_request(input t_in_req req, output t_out_res res);
        int  pos;
        int  i;
        bit  in_list;
        pos            = int'(req.position);
        in_list        = (pos >= 1) && (pos <= shadow_count);
        res.data       = -32'sd1;
        res.status     = ST_INVALID;
        case (req.action)
            ACT_READ: begin
                if (in_list) begin
                    res.data   = shadow_words[pos-1];
                    res.status = ST_OK;
                end
            end
            ACT_WRITE: begin
                if (in_list) begin
                    shadow_words[pos-1] = req.value;
                    res.data            = req.value;
                    res.status          = ST_OK;
                end
            end
            ACT_INSERT: begin
                if (pos >= 1 && pos <= shadow_count + 1) begin
                    res.data = req.value;
                    if (shadow_count >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = shadow_count; i > pos - 1; i--)
                            shadow_words[i] = shadow_words[i-1];
                        shadow_words[pos-1] = req.value;
                        shadow_count++;
                        res.status = ST_OK;
                    end
                end
            end
            default: begin
                if (in_list) begin
                    res.data = shadow_words[pos-1];
                    for (i = pos - 1; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                    res.status = ST_OK;
                end
            end
        endcase
        res.length    = LW'(shadow_count);
        res.empty_res = (shadow_count == 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            shadow_count = 0;
        end else begin
            // A result never comes out at the edge that takes its own request, so check first.
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", i_out_res.data, 32'd0);
                end else begin
                    oldest_res = expected_q.pop_front();
                    if (i_out_res.data !== oldest_res.data)
                        report_mismatch("data", i_out_res.data, oldest_res.data);
                    if (i_out_res.status !== oldest_res.status)
                        report_mismatch("status", 32'(i_out_res.status),
                                        32'(oldest_res.status));
                    if (i_out_res.length !== oldest_res.length)
                        report_mismatch("length", 32'(i_out_res.length),
                                        32'(oldest_res.length));
                    if (i_out_res.empty_res !== oldest_res.empty_res)
                        report_mismatch("empty_res", 32'(i_out_res.empty_res),
                                        32'(oldest_res.empty_res));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_in_req, predicted_res);
                expected_q.push_back(predicted_res);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

/* tb/tb_positional_list_store_core.sv */
// Testbench top: drives requests into the positional list store and gives the verdict.
`default_nettype none

module tb_positional_list_store_core;
    import plsc_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_res o_out_res;

    int       fail_count;
    int       pending_count;

    // Idle rates in percent for the sender and the receiver.
    int       tx_idle_pct;
    int       rx_stall_pct;

    // Length the list will have once every request issued so far is done.
    // Used only to steer positions towards valid ones.
    int       list_len;
    bit       draining;

    positional_list_store_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    positional_list_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_res   (o_out_res),
        .o_errors    (fail_count),
        .o_pending   (pending_count)
    );

    // Clock: period of 8.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: stall at random at the configured rate, drawn fresh each cycle.
    always @(posedge i_clk) begin
        i_out_stall <= (rx_stall_pct > 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("tb_positional_list_store_core: done, errors");
        $finish;
    end

    // Issue one request and hold it until the block takes it. Keep valid high
    // straight into the next request when no idle gap is drawn, so valid is
    // never dropped and raised in the same step.
    task automatic issue_request(input t_action act, input int pos, input logic [31:0] val);
        t_in_req req;
        req.action   = act;
        req.position = POSW'(pos);
        req.value    = val;
        // Track the length the block will reach, to aim later positions.
        if (act == ACT_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < DEPTH)
            list_len++;
        else if (act == ACT_REMOVE && pos >= 1 && pos <= list_len)
            list_len--;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    // Sample the count at the falling edge, clear of the checker's update.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        @(posedge i_clk);
    endtask

    // Random requests: mostly well-formed commands aimed at valid positions,
    // swinging the list between empty and full, with some noise mixed in.
    task automatic run_random(input int n_items);
        int          k;
        int          roll;
        int          pos;
        t_action     act;
        logic [31:0] val;
        for (k = 0; k < n_items; k++) begin
            if (list_len >= DEPTH && $urandom_range(0, 99) < 30)
                draining = 1'b1;
            else if (list_len == 0)
                draining = 1'b0;

            // Favour the word extremes now and then.
            case ($urandom_range(0, 19))
                0:       val = 32'h7fff_ffff;
                1:       val = 32'h8000_0000;
                2:       val = 32'hffff_ffff;
                3:       val = 32'h0000_0000;
                default: val = $urandom;
            endcase

            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                // Noise: any action at any position.
                act = t_action'($urandom_range(0, 3));
                pos = $urandom_range(0, 31);
            end else begin
                roll = $urandom_range(0, 99);
                if (draining) begin
                    if (roll < 20)      act = ACT_INSERT;
                    else if (roll < 65) act = ACT_REMOVE;
                    else if (roll < 85) act = ACT_READ;
                    else                act = ACT_WRITE;
                end else begin
                    if (roll < 45)      act = ACT_INSERT;
                    else if (roll < 65) act = ACT_REMOVE;
                    else if (roll < 85) act = ACT_READ;
                    else                act = ACT_WRITE;
                end
                // Nothing but insert has a valid position on an empty list.
                if (list_len == 0)
                    act = ACT_INSERT;
                if (act == ACT_INSERT)
                    pos = $urandom_range(1, list_len + 1);
                else
                    pos = $urandom_range(1, list_len);
            end
            issue_request(act, pos, val);
        end
    endtask

    initial begin
        int k;

        // Known values on every input from time zero.
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_req     = '0;
        i_out_stall  = 1'b0;
        tx_idle_pct  = 32;
        rx_stall_pct = 65;
        list_len     = 0;
        draining     = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every action against an empty list, all invalid.
        issue_request(ACT_READ,   0, 32'h0000_0000);
        issue_request(ACT_WRITE,  1, 32'h1234_5678);
        issue_request(ACT_REMOVE, 1, 32'h0000_0000);
        issue_request(ACT_INSERT, 0, 32'h0bad_0bad);
        // Insert beyond length plus one.
        issue_request(ACT_INSERT, 2, 32'h0bad_0bad);

        // Build a short list: first, append, head and middle inserts.
        issue_request(ACT_INSERT, 1, 32'h8000_0000);
        issue_request(ACT_INSERT, 2, 32'h7fff_ffff);
        issue_request(ACT_INSERT, 1, 32'hffff_ffff);
        issue_request(ACT_INSERT, 2, 32'h0000_0000);
        issue_request(ACT_WRITE,  3, 32'h5a5a_5a5a);

        // Fill to capacity.
        for (k = 0; k < DEPTH - 4; k++)
            issue_request(ACT_INSERT, $urandom_range(1, list_len + 1), $urandom);

        // Full store: valid position gives full, bad position is invalid first.
        issue_request(ACT_INSERT, DEPTH + 1, 32'hcafe_f00d);
        issue_request(ACT_INSERT, DEPTH + 2, 32'hcafe_f00d);
        issue_request(ACT_READ,   DEPTH,     32'h0000_0000);
        issue_request(ACT_READ,   31,        32'h0000_0000);

        // Remove from head, tail and middle.
        issue_request(ACT_REMOVE, 1,         32'h0000_0000);
        issue_request(ACT_REMOVE, DEPTH - 1, 32'h0000_0000);
        issue_request(ACT_REMOVE, 7,         32'h0000_0000);

        // Hold off until the block has answered everything.
        drain_results();

        // Random: sender idles less than the receiver stalls.
        run_random(150);
        drain_results();

        // Random: the other way round.
        tx_idle_pct  = 65;
        rx_stall_pct = 32;
        run_random(150);
        drain_results();

        // Random: full rate on both sides.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(150);
        drain_results();

        // Allow for a stray late result before giving the verdict.
        repeat (40) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_positional_list_store_core: done, clean");
        else
            $display("tb_positional_list_store_core: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
